// File: design/fpss_pkg.sv
`default_nettype none

package fpss_pkg;

   // Field and storage widths
   localparam int VAL_W     = 48;
   localparam int THR_W     = 47;
   localparam int SIZE_W    = 9;
   localparam int SWEEP_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int MAX_COLS  = 256;
   localparam int MAX_ROWS  = 256;
   localparam int MIN_SIZE  = 3;
   localparam int POS_W     = $clog2(MAX_COLS);

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_ROWS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_ROW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LAST_ROW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_COL = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LAST_COL  = 3'd6;

   typedef logic signed [VAL_W-1:0] value_type;
   typedef logic [POS_W-1:0]        pos_type;

   // Register reset values
   localparam logic [SIZE_W-1:0] ROWS_RESET      = 9'd256;
   localparam logic [SIZE_W-1:0] COLS_RESET      = 9'd200;
   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 47'd655;
   localparam value_type         FIRST_ROW_RESET = 48'sd655360;
   localparam value_type         LAST_ROW_RESET  = 48'sd327680;
   localparam value_type         FIRST_COL_RESET = 48'sd1012531;
   localparam value_type         LAST_COL_RESET  = -48'sd439091;

   // Bounds of the 48-bit range, held in a 50-bit word
   localparam logic signed [VAL_W+1:0] WIDE_MAX = {3'b000, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W+1:0] WIDE_MIN = {3'b111, {(VAL_W-1){1'b0}}};

   // Decoded configuration seen by the datapath
   typedef struct packed {
      pos_type           rows_last;
      pos_type           cols_last;
      logic [THR_W-1:0]  threshold;
      value_type         first_row_edge;
      value_type         last_row_edge;
      value_type         first_col_edge;
      value_type         last_col_edge;
   } cfg_type;

   // Tags that travel with a finished cell
   typedef struct packed {
      logic [SWEEP_W-1:0] sweep;
      pos_type            row;
      pos_type            col;
      logic               last_of_run;
      logic               end_of_sweep;
   } meta_type;

   // One cell to finish: its four neighbours and its own value
   typedef struct packed {
      value_type up;
      value_type down;
      value_type left;
      value_type right;
      value_type old;
      meta_type  meta;
   } job_type;

   // Clip a wide sum to the signed 48-bit range
   function automatic value_type sat_value(input logic signed [VAL_W+1:0] x);
      value_type res;
      if (x > WIDE_MAX) begin
         res = {1'b0, {(VAL_W-1){1'b1}}};
      end else if (x < WIDE_MIN) begin
         res = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         res = x[VAL_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: design/fpss_ram.sv
`default_nettype none

module fpss_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port; a read of the entry being
   // written returns the old contents. Read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/fpss_seq.sv
`default_nettype none

module fpss_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fpss_pkg::cfg_type  cfg,
   input  wire logic               restart,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire fpss_pkg::value_type req_value,
   output logic                    job_valid,
   input  wire logic               job_ready,
   output fpss_pkg::job_type       job
);

   // Which finished cell the held request is producing
   localparam logic [1:0] JOB_A = 2'd0;  // cell one row up
   localparam logic [1:0] JOB_B = 2'd1;  // last row, cell to the left
   localparam logic [1:0] JOB_C = 2'd2;  // final cell of the sweep

   localparam int VW = fpss_pkg::VAL_W;
   localparam int PW = fpss_pkg::POS_W;

   // Stream position
   fpss_pkg::pos_type            row_ff, col_ff;
   logic [fpss_pkg::SWEEP_W-1:0] sweep_ff;
   fpss_pkg::value_type          head_ff;   // column 0 of the latest row

   // Held request
   logic                         s1_valid_ff;
   logic [1:0]                   phase_ff;
   fpss_pkg::pos_type            s1_row_ff, s1_col_ff;
   fpss_pkg::value_type          s1_value_ff, s1_head_ff;
   logic [fpss_pkg::SWEEP_W-1:0] s1_sweep_ff;
   logic                         s1_odd_ff, s1_need_b_ff, s1_need_c_ff;
   logic                         s1_top_ff, s1_left_ff, s1_right_ff;

   // Sliding windows: row above at c-1 and c, current row at c-2 and c-1
   fpss_pkg::value_type          win_l_ff, win_m_ff, cur_l_ff, cur_m_ff;

   logic                         accept, has_jobs, at_row_last, at_col_last;
   logic                         job_last, s1_done, s1_free;
   fpss_pkg::pos_type            addr_next;
   logic [VW-1:0]                even_rd, odd_rd;
   fpss_pkg::value_type          above_data, right_data, old_a;
   logic                         corner;

   assign at_row_last = (row_ff == cfg.rows_last);
   assign at_col_last = (col_ff == cfg.cols_last);
   assign has_jobs    = (row_ff != '0);
   assign addr_next   = col_ff + PW'(1);

   // Handshake: take a new request once the held one has issued its last job
   always_comb begin
      unique case (phase_ff)
         JOB_A:   job_last = !s1_need_b_ff;
         JOB_B:   job_last = !s1_need_c_ff;
         default: job_last = 1'b1;
      endcase
   end

   assign s1_done   = s1_valid_ff && job_ready && job_last;
   assign s1_free   = !s1_valid_ff || s1_done;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   // Even rows live in one store, odd rows in the other. The store of the
   // current row is read at c (two rows up) and written at c in the same
   // cycle; the other store is read one column ahead.
   fpss_ram #(.WIDTH(VW), .DEPTH(fpss_pkg::MAX_COLS)) u_even_ram (
      .clock   (clock),
      .wr_en   (accept && !row_ff[0]),
      .wr_addr (col_ff),
      .wr_data (req_value),
      .rd_en   (accept && has_jobs),
      .rd_addr (row_ff[0] ? addr_next : col_ff),
      .rd_data (even_rd)
   );

   fpss_ram #(.WIDTH(VW), .DEPTH(fpss_pkg::MAX_COLS)) u_odd_ram (
      .clock   (clock),
      .wr_en   (accept && row_ff[0]),
      .wr_addr (col_ff),
      .wr_data (req_value),
      .rd_en   (accept && has_jobs),
      .rd_addr (row_ff[0] ? col_ff : addr_next),
      .rd_data (odd_rd)
   );

   assign above_data = s1_odd_ff ? $signed(odd_rd) : $signed(even_rd);
   assign right_data = s1_odd_ff ? $signed(even_rd) : $signed(odd_rd);
   assign old_a      = s1_left_ff ? s1_head_ff : win_m_ff;

   // Position and sweep count
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         sweep_ff <= '0;
      end else if (restart) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         if (at_col_last) begin
            col_ff <= '0;
            if (at_row_last) begin
               row_ff   <= '0;
               sweep_ff <= sweep_ff + fpss_pkg::SWEEP_W'(1);
            end else begin
               row_ff <= row_ff + PW'(1);
            end
         end else begin
            col_ff <= col_ff + PW'(1);
         end
      end
   end

   // Holding register control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         phase_ff    <= JOB_A;
      end else begin
         if (accept) begin
            s1_valid_ff <= has_jobs;
         end else if (s1_done) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_valid_ff && job_ready) begin
            if (job_last) begin
               phase_ff <= JOB_A;
            end else if (phase_ff == JOB_A) begin
               phase_ff <= JOB_B;
            end else begin
               phase_ff <= JOB_C;
            end
         end
      end
   end

   // Holding register payload and windows
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff    <= row_ff;
         s1_col_ff    <= col_ff;
         s1_value_ff  <= req_value;
         s1_head_ff   <= head_ff;
         s1_sweep_ff  <= sweep_ff;
         s1_odd_ff    <= row_ff[0];
         s1_need_b_ff <= at_row_last && (col_ff != '0);
         s1_need_c_ff <= at_row_last && at_col_last;
         s1_top_ff    <= (row_ff == PW'(1));
         s1_left_ff   <= (col_ff == '0);
         s1_right_ff  <= at_col_last;
         if (col_ff == '0) begin
            head_ff <= req_value;
         end
      end
      if (s1_done) begin
         win_l_ff <= old_a;
         win_m_ff <= right_data;
         cur_l_ff <= cur_m_ff;
         cur_m_ff <= s1_value_ff;
      end
   end

   // Gather the operands of the cell being finished
   always_comb begin
      job.up                = '0;
      job.down              = '0;
      job.left              = '0;
      job.right             = '0;
      job.old               = s1_value_ff;
      job.meta.sweep        = s1_sweep_ff;
      job.meta.row          = s1_row_ff;
      job.meta.col          = s1_col_ff;
      job.meta.last_of_run  = 1'b1;
      job.meta.end_of_sweep = 1'b1;
      corner                = 1'b1;
      unique case (phase_ff)
         JOB_A: begin
            corner                = s1_top_ff && (s1_left_ff || s1_right_ff);
            job.up                = s1_top_ff ? cfg.first_row_edge : above_data;
            job.down              = s1_value_ff;
            job.left              = s1_left_ff ? cfg.first_col_edge : win_l_ff;
            job.right             = s1_right_ff ? cfg.last_col_edge : right_data;
            job.old               = old_a;
            job.meta.row          = s1_row_ff - PW'(1);
            job.meta.last_of_run  = !s1_need_b_ff;
            job.meta.end_of_sweep = 1'b0;
         end
         JOB_B: begin
            // bottom-left corner when the left cell is column 0
            corner                = (s1_col_ff == PW'(1));
            job.up                = win_l_ff;
            job.down              = cfg.last_row_edge;
            job.left              = cur_l_ff;
            job.right             = s1_value_ff;
            job.old               = cur_m_ff;
            job.meta.col          = s1_col_ff - PW'(1);
            job.meta.last_of_run  = !s1_need_c_ff;
            job.meta.end_of_sweep = 1'b0;
         end
         default: ;
      endcase
      // corners take a stencil of zero
      if (corner) begin
         job.up    = '0;
         job.down  = '0;
         job.left  = '0;
         job.right = '0;
      end
   end

   assign job_valid = s1_valid_ff;

endmodule

`default_nettype wire

// File: design/fpss_eval.sv
`default_nettype none

module fpss_eval (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [fpss_pkg::THR_W-1:0]  threshold,
   input  wire logic                        job_valid,
   output logic                             job_ready,
   input  wire fpss_pkg::job_type           job,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output fpss_pkg::meta_type               rsp_meta,
   output fpss_pkg::value_type              rsp_old_value,
   output fpss_pkg::value_type              rsp_stencil_value,
   output fpss_pkg::value_type              rsp_new_value,
   output logic                             rsp_near_match
);

   localparam int VW = fpss_pkg::VAL_W;

   logic e1_valid_ff, e2_valid_ff, e3_valid_ff, out_valid_ff;
   logic e2_ready, e3_ready, out_ready;

   // Pair sums
   logic signed [VW:0]  e1_ud_ff, e1_lr_ff, ud_in, lr_in;
   fpss_pkg::value_type e1_old_ff;
   fpss_pkg::meta_type  e1_meta_ff;

   // Stencil value
   logic signed [VW+1:0] total;
   fpss_pkg::value_type  e2_stencil_ff, e2_old_ff, stencil_in;
   fpss_pkg::meta_type   e2_meta_ff;

   // Relaxed value and magnitudes
   fpss_pkg::value_type  e3_stencil_ff, e3_old_ff, e3_new_ff, new_in, old_half, st_half;
   logic signed [VW:0]   half_sum;
   logic [VW-1:0]        e3_abs_st_ff, e3_abs_old_ff, abs_st_in, abs_old_in;
   fpss_pkg::meta_type   e3_meta_ff;

   // Output register
   fpss_pkg::value_type  out_stencil_ff, out_old_ff, out_new_ff;
   fpss_pkg::meta_type   out_meta_ff;
   logic                 out_near_ff, near_in;
   logic signed [VW:0]   diff_a, diff_b, thr_wide;

   // Stage flow: a stage takes new data when empty or when it moves on
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign e3_ready  = !e3_valid_ff || out_ready;
   assign e2_ready  = !e2_valid_ff || e3_ready;
   assign job_ready = !e1_valid_ff || e2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff  <= 1'b0;
         e2_valid_ff  <= 1'b0;
         e3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (job_ready) begin
            e1_valid_ff <= job_valid;
         end
         if (e2_ready) begin
            e2_valid_ff <= e1_valid_ff;
         end
         if (e3_ready) begin
            e3_valid_ff <= e2_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= e3_valid_ff;
         end
      end
   end

   // Stage 1: up+down and left+right, exact in 49 bits
   assign ud_in = $signed({job.up[VW-1], job.up}) + $signed({job.down[VW-1], job.down});
   assign lr_in = $signed({job.left[VW-1], job.left}) + $signed({job.right[VW-1], job.right});

   // Stage 2: full sum, clip, divide by four
   assign total      = $signed({e1_ud_ff[VW], e1_ud_ff}) + $signed({e1_lr_ff[VW], e1_lr_ff});
   assign stencil_in = fpss_pkg::sat_value(total) >>> 2;

   // Stage 3: old/2 + stencil/2 clipped, and both magnitudes
   assign old_half   = e2_old_ff >>> 1;
   assign st_half    = e2_stencil_ff >>> 1;
   assign half_sum   = $signed({old_half[VW-1], old_half}) + $signed({st_half[VW-1], st_half});
   assign new_in     = fpss_pkg::sat_value($signed({half_sum[VW], half_sum}));
   assign abs_st_in  = e2_stencil_ff[VW-1] ? VW'(-e2_stencil_ff) : VW'(e2_stencil_ff);
   assign abs_old_in = e2_old_ff[VW-1] ? VW'(-e2_old_ff) : VW'(e2_old_ff);

   // Stage 4: |a-b| < t is a-b < t and b-a < t
   assign diff_a   = $signed({1'b0, e3_abs_st_ff}) - $signed({1'b0, e3_abs_old_ff});
   assign diff_b   = $signed({1'b0, e3_abs_old_ff}) - $signed({1'b0, e3_abs_st_ff});
   assign thr_wide = $signed({2'b00, threshold});
   assign near_in  = (diff_a < thr_wide) && (diff_b < thr_wide);

   always_ff @(posedge clock) begin
      if (job_ready && job_valid) begin
         e1_ud_ff   <= ud_in;
         e1_lr_ff   <= lr_in;
         e1_old_ff  <= job.old;
         e1_meta_ff <= job.meta;
      end
      if (e2_ready && e1_valid_ff) begin
         e2_stencil_ff <= stencil_in;
         e2_old_ff     <= e1_old_ff;
         e2_meta_ff    <= e1_meta_ff;
      end
      if (e3_ready && e2_valid_ff) begin
         e3_stencil_ff <= e2_stencil_ff;
         e3_old_ff     <= e2_old_ff;
         e3_new_ff     <= new_in;
         e3_abs_st_ff  <= abs_st_in;
         e3_abs_old_ff <= abs_old_in;
         e3_meta_ff    <= e2_meta_ff;
      end
      if (out_ready && e3_valid_ff) begin
         out_stencil_ff <= e3_stencil_ff;
         out_old_ff     <= e3_old_ff;
         out_new_ff     <= e3_new_ff;
         out_near_ff    <= near_in;
         out_meta_ff    <= e3_meta_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_meta          = out_meta_ff;
   assign rsp_old_value     = out_old_ff;
   assign rsp_stencil_value = out_stencil_ff;
   assign rsp_new_value     = out_new_ff;
   assign rsp_near_match    = out_near_ff;

endmodule

`default_nettype wire

// File: design/five_point_stencil_sweep.sv
// Five-point stencil sweep over a grid streamed in raster order.
// Request channel (req_valid/req_stall/req_cell_value): one grid cell per
// request, row after row, starting at cell (0,0) after reset or after a write
// of the row or column count. The sweep wraps to (0,0) by itself.
// Response channel (rsp_*): one response per finished cell. A cell is
// finished when the cell below it arrives; the last row finishes on the fly.
// Row 0 requests give no response, middle rows one each, last-row requests
// two (one only at column 0), and the final cell of the sweep three.
// rsp_last_of_run marks the last response of a request.
// Throughput is one request per cycle while rsp_stall is low, bounded by the
// single response port: on the last row a request holds the port for each of its responses.
// The first response of a request passes through the hold register, pair
// sums, stencil, relax and output registers in that order.
// Two line stores (even rows, odd rows) of one read and one write port each
// supply the neighbours; they are not cleared and need no warm-up.
// Reset sets the counters to zero and the registers to their defaults.
// When rsp_stall is high the response holds and the pipeline fills; req_stall
// rises once no stage is free. csr writes are taken at once; the user must make
// csr writes only while the block is idle, as the block itself does not enforce it.
`default_nettype none

module five_point_stencil_sweep (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire fpss_pkg::value_type             req_cell_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [fpss_pkg::SWEEP_W-1:0]         rsp_sweep_index,
   output fpss_pkg::pos_type                    rsp_out_row,
   output fpss_pkg::pos_type                    rsp_out_col,
   output fpss_pkg::value_type                  rsp_old_value,
   output fpss_pkg::value_type                  rsp_stencil_value,
   output fpss_pkg::value_type                  rsp_new_value,
   output logic                                 rsp_near_match,
   output logic                                 rsp_last_of_run,
   output logic                                 rsp_end_of_sweep,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [fpss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fpss_pkg::VAL_W-1:0]      csr_data
);

   localparam int SW = fpss_pkg::SIZE_W;
   localparam int PW = fpss_pkg::POS_W;

   logic [SW-1:0]              rows_ff, cols_ff;
   logic [fpss_pkg::THR_W-1:0] thr_ff;
   fpss_pkg::value_type        first_row_ff, last_row_ff, first_col_ff, last_col_ff;
   fpss_pkg::cfg_type          cfg;
   logic                       restart;
   logic                       job_valid, job_ready;
   fpss_pkg::job_type          job;
   fpss_pkg::meta_type         rsp_meta;

   // Clamp a size to [MIN_SIZE, max] and return the index of its last entry
   function automatic fpss_pkg::pos_type size_last(input logic [SW-1:0] size,
                                                   input int max_size);
      fpss_pkg::pos_type res;
      if (size < SW'(fpss_pkg::MIN_SIZE)) begin
         res = PW'(fpss_pkg::MIN_SIZE - 1);
      end else if (size > SW'(max_size)) begin
         res = PW'(max_size - 1);
      end else begin
         res = PW'(size - SW'(1));
      end
      return res;
   endfunction

   // Register file; writes always complete
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= fpss_pkg::ROWS_RESET;
         cols_ff      <= fpss_pkg::COLS_RESET;
         thr_ff       <= fpss_pkg::THRESHOLD_RESET;
         first_row_ff <= fpss_pkg::FIRST_ROW_RESET;
         last_row_ff  <= fpss_pkg::LAST_ROW_RESET;
         first_col_ff <= fpss_pkg::FIRST_COL_RESET;
         last_col_ff  <= fpss_pkg::LAST_COL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            fpss_pkg::REG_ROWS:      rows_ff      <= csr_data[SW-1:0];
            fpss_pkg::REG_COLS:      cols_ff      <= csr_data[SW-1:0];
            fpss_pkg::REG_THRESHOLD: thr_ff       <= csr_data[fpss_pkg::THR_W-1:0];
            fpss_pkg::REG_FIRST_ROW: first_row_ff <= $signed(csr_data);
            fpss_pkg::REG_LAST_ROW:  last_row_ff  <= $signed(csr_data);
            fpss_pkg::REG_FIRST_COL: first_col_ff <= $signed(csr_data);
            fpss_pkg::REG_LAST_COL:  last_col_ff  <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // A new grid size starts the sweep over
   assign restart = csr_valid &&
                    (csr_index == fpss_pkg::REG_ROWS || csr_index == fpss_pkg::REG_COLS);

   always_comb begin
      cfg.rows_last      = size_last(rows_ff, fpss_pkg::MAX_ROWS);
      cfg.cols_last      = size_last(cols_ff, fpss_pkg::MAX_COLS);
      cfg.threshold      = thr_ff;
      cfg.first_row_edge = first_row_ff;
      cfg.last_row_edge  = last_row_ff;
      cfg.first_col_edge = first_col_ff;
      cfg.last_col_edge  = last_col_ff;
   end

   // Line stores and neighbour gathering
   fpss_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .restart   (restart),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_cell_value),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   // Arithmetic pipeline and response register
   fpss_eval u_eval (
      .clock             (clock),
      .reset             (reset),
      .threshold         (thr_ff),
      .job_valid         (job_valid),
      .job_ready         (job_ready),
      .job               (job),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_meta          (rsp_meta),
      .rsp_old_value     (rsp_old_value),
      .rsp_stencil_value (rsp_stencil_value),
      .rsp_new_value     (rsp_new_value),
      .rsp_near_match    (rsp_near_match)
   );

   assign rsp_sweep_index  = rsp_meta.sweep;
   assign rsp_out_row      = rsp_meta.row;
   assign rsp_out_col      = rsp_meta.col;
   assign rsp_last_of_run  = rsp_meta.last_of_run;
   assign rsp_end_of_sweep = rsp_meta.end_of_sweep;

endmodule

`default_nettype wire
